// ===== hw/rtl/p2fl_pkg.sv =====
// ----------------------------------------------------------------------------
// p2fl_pkg
// Shared sizes, codes and state encoding of the power-of-two free-list
// allocator.
// ----------------------------------------------------------------------------
package p2fl_pkg;

   // Highest block level and number of fresh chunks in the pool
   localparam int MAX_LEVEL   = 16;
   localparam int POOL_CHUNKS = 16;

   // Derived level sizes
   localparam int LEVELS  = MAX_LEVEL + 1;
   localparam int LIDX_W  = $clog2(LEVELS);
   localparam int CHUNK_LOG = MAX_LEVEL + 1;

   // Field widths
   localparam int ADDR_W  = 21;
   localparam int BYTES_W = 17;
   localparam int GRAN_W  = 5;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = $clog2(POOL_CHUNKS + 1);

   // Rounded capacity must hold the largest rounded size and 2^MAX_LEVEL
   localparam int CAP_W = (MAX_LEVEL + 2 > BYTES_W + 1) ? MAX_LEVEL + 2 : BYTES_W + 1;
   localparam int LVL_W = $clog2(CAP_W + 1);

   // Link store: one entry per minimum granule of the address space
   localparam int LINK_SHIFT = 12;
   localparam int LINK_AW    = ADDR_W - LINK_SHIFT;
   localparam int LINK_DEPTH = 1 << LINK_AW;
   localparam int LINK_W     = ADDR_W + 1;

   // Granule clamp range
   localparam logic [GRAN_W-1:0] GRAN_MIN   = GRAN_W'(12);
   localparam logic [GRAN_W-1:0] GRAN_MAX   = GRAN_W'(16);
   localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(12);

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_OOM       = 2'd1,
      ST_TOO_LARGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_DISPATCH,
      S_POP,
      S_SPLIT,
      S_DONE
   } state_type;

endpackage

// ===== hw/rtl/pow2_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// pow2_free_list_allocator
// Segregated free-list allocator with one stack per power-of-two level, a
// bump-pointer chunk pool and a split path that pushes lower halves.
// ----------------------------------------------------------------------------
// Sequence: word accepted, then decode, dispatch, a pop step when a list
// serves the request, a split step for each level split, then done; rsp_valid
// rises when the result moves into the output register.
// Throughput: one word at a time; the next word is taken only after the
// result moves into the output register, which waits on rsp_stall. Each
// split level costs one link store write and one list head update.
// Reset: all lists empty, no chunks taken, granule 2^12; link store is not
// cleared.
module pow2_free_list_allocator
   import p2fl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [BYTES_W-1:0] req_request_bytes,
   input  logic [ADDR_W-1:0]  req_block_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ADDR_W-1:0]  rsp_granted_address,
   output logic [STAT_W-1:0]  rsp_status,
   input  logic               csr_write_enable,
   input  logic [GRAN_W-1:0]  csr_write_data
);

   // State and registers
   state_type          state_ff, state_in;
   logic [GRAN_W-1:0]  granule_ff;
   logic               op_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [ADDR_W-1:0]  baddr_ff;
   logic [LIDX_W-1:0]  level_ff, level_in;
   logic               too_large_ff, too_large_in;
   logic [ADDR_W-1:0]  blk_ff, blk_in;
   logic [LVL_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]   chunks_ff, chunks_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   status_type         rsp_status_ff;

   // List heads: address array plus empty flags
   logic [ADDR_W-1:0]  heads_ff [LEVELS];
   logic [LEVELS-1:0]  empty_ff;

   // Link store
   logic [LINK_W-1:0]  link_mem [LINK_DEPTH];
   logic [LINK_W-1:0]  link_rdata_ff;

   // Control outputs of the sequencer
   logic               link_we, link_re;
   logic [LINK_AW-1:0] link_waddr, link_raddr;
   logic [LINK_W-1:0]  link_wdata;
   logic               head_we;
   logic [LIDX_W-1:0]  head_widx;
   logic [ADDR_W-1:0]  head_waddr;
   logic               head_wempty;
   logic               rsp_load;

   // Datapath helpers
   logic [GRAN_W-1:0]  gran_eff;
   logic [CAP_W-1:0]   gmask, size_ext, cap, cap_m1;
   logic [LVL_W-1:0]   lvl_calc;
   logic               found;
   logic [LIDX_W-1:0]  found_b;
   logic [LVL_W-1:0]   nxt_lvl;
   logic [LIDX_W-1:0]  split_idx;
   logic [ADDR_W-1:0]  split_step;
   logic [LIDX_W-1:0]  head_ridx;
   logic [ADDR_W-1:0]  head_rd;
   logic               head_rd_empty;
   logic [ADDR_W+CNT_W-1:0] chunk_wide;
   logic [ADDR_W-1:0]  chunk_base;
   logic               pool_full;
   logic               out_free;

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign out_free            = !rsp_valid_ff || !rsp_stall;

   // Round the size up to the granule and then to a power of two
   always_comb begin
      if (granule_ff < GRAN_MIN) begin
         gran_eff = GRAN_MIN;
      end else if (granule_ff > GRAN_MAX) begin
         gran_eff = GRAN_MAX;
      end else begin
         gran_eff = granule_ff;
      end
      gmask    = (CAP_W'(1) << gran_eff) - CAP_W'(1);
      size_ext = (bytes_ff == '0) ? CAP_W'(1) : CAP_W'(bytes_ff);
      cap      = (size_ext + gmask) & ~gmask;
      cap_m1   = cap - CAP_W'(1);
      too_large_in = (cap > (CAP_W'(1) << MAX_LEVEL));
      lvl_calc = '0;
      for (int i = 0; i < CAP_W; i++) begin
         if (cap_m1[i]) lvl_calc = LVL_W'(i + 1);
      end
      level_in = lvl_calc[LIDX_W-1:0];
   end

   // Find the lowest non-empty level at or above the request level
   always_comb begin
      found   = 1'b0;
      found_b = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (!empty_ff[i] && (LIDX_W'(i) >= level_ff)) begin
            found   = 1'b1;
            found_b = LIDX_W'(i);
         end
      end
   end

   // Split step and fresh chunk base
   assign nxt_lvl    = cur_ff - LVL_W'(1);
   assign split_idx  = nxt_lvl[LIDX_W-1:0];
   assign split_step = ADDR_W'(1) << split_idx;
   assign chunk_wide = {{ADDR_W{1'b0}}, chunks_ff} << CHUNK_LOG;
   assign chunk_base = chunk_wide[ADDR_W-1:0];
   assign pool_full  = (chunks_ff >= CNT_W'(POOL_CHUNKS));

   // Single head read port
   always_comb begin
      head_ridx = level_ff;
      if (state_ff == S_DISPATCH && op_ff == OP_ALLOC) begin
         head_ridx = found_b;
      end else if (state_ff == S_SPLIT) begin
         head_ridx = split_idx;
      end
   end
   assign head_rd       = heads_ff[head_ridx];
   assign head_rd_empty = empty_ff[head_ridx];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (too_large_ff || op_ff == OP_FREE) begin
               state_in = S_DONE;
            end else if (found) begin
               state_in = S_POP;
            end else if (pool_full) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_POP: begin
            state_in = (cur_ff == LVL_W'(level_ff)) ? S_DONE : S_SPLIT;
         end
         S_SPLIT: begin
            if (split_idx == level_ff) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      link_we       = 1'b0;
      link_re       = 1'b0;
      link_raddr    = head_rd[ADDR_W-1:LINK_SHIFT];
      link_wdata    = {head_rd_empty, head_rd};
      head_we       = 1'b0;
      head_widx     = head_ridx;
      head_waddr    = blk_ff;
      head_wempty   = 1'b0;
      blk_in        = blk_ff;
      cur_in        = cur_ff;
      chunks_in     = chunks_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_load      = 1'b0;
      unique case (state_ff)
         S_IDLE, S_DECODE: begin
         end
         S_DISPATCH: begin
            res_addr_in   = '0;
            res_status_in = ST_OK;
            if (too_large_ff) begin
               res_status_in = ST_TOO_LARGE;
            end else if (op_ff == OP_FREE) begin
               // push the freed block on its level
               head_waddr = baddr_ff;
               link_we    = 1'b1;
               head_we    = 1'b1;
            end else if (found) begin
               // start the pop: fetch the link of the head block
               link_re = 1'b1;
               blk_in  = head_rd;
               cur_in  = LVL_W'(found_b);
            end else if (pool_full) begin
               res_status_in = ST_OOM;
            end else begin
               // take a fresh chunk from the bump pointer
               blk_in    = chunk_base;
               cur_in    = LVL_W'(LEVELS);
               chunks_in = chunks_ff + CNT_W'(1);
            end
         end
         S_POP: begin
            // advance the popped list head to the fetched link
            head_we     = 1'b1;
            head_widx   = cur_ff[LIDX_W-1:0];
            head_waddr  = link_rdata_ff[ADDR_W-1:0];
            head_wempty = link_rdata_ff[ADDR_W];
            res_addr_in = blk_ff;
         end
         S_SPLIT: begin
            // push the lower half, keep the upper half
            link_we     = 1'b1;
            head_we     = 1'b1;
            blk_in      = blk_ff + split_step;
            cur_in      = nxt_lvl;
            res_addr_in = blk_ff + split_step;
         end
         S_DONE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
      // link entry of the block being pushed
      link_waddr = head_waddr[ADDR_W-1:LINK_SHIFT];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         granule_ff   <= GRAN_RESET;
         chunks_ff    <= '0;
         empty_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         chunks_ff <= chunks_in;
         if (csr_write_enable) granule_ff <= csr_write_data;
         if (head_we) empty_ff[head_widx] <= head_wempty;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         op_ff    <= req_operation;
         bytes_ff <= req_request_bytes;
         baddr_ff <= req_block_address;
      end
      if (state_ff == S_DECODE) begin
         level_ff     <= level_in;
         too_large_ff <= too_large_in;
      end
      blk_ff        <= blk_in;
      cur_ff        <= cur_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (head_we) heads_ff[head_widx] <= head_waddr;
      if (rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // Link store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_re) link_rdata_ff <= link_mem[link_raddr];
   end

endmodule
